[hdl/ima_adpcm_packet_decoder_assert.svh]
// Assertion macros for the IMA ADPCM packet decoder top module.
`ifndef IMA_ADPCM_PACKET_DECODER_ASSERT_SVH
`define IMA_ADPCM_PACKET_DECODER_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle.
`define IMADEC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imadec assertion failed");

// Check that a condition implies a consequence in the following cycle.
`define IMADEC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imadec assertion failed");

`endif

[hdl/imadec_pkg.sv]
// Types, constants and step tables for the IMA ADPCM packet decoder.
package imadec_pkg;

   localparam int unsigned MAX_STEP_INDEX        = 88;
   localparam int unsigned HDR_BYTES_PER_CHANNEL = 4;

   // channel_count codes
   localparam logic [1:0] CHANNELS_MONO   = 2'd1;
   localparam logic [1:0] CHANNELS_STEREO = 2'd2;

   // result_kind codes
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_ERROR  = 1'b1;

   localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;
   localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        packet_start;
      logic [15:0] packet_bytes;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [15:0] sample_value;
      logic               channel_number;
      logic [8:0]         subframe_number;
      logic [7:0]         sample_position;
      logic               last_of_item;
      logic               end_of_packet;
   } rsp_type;

   // work queued behind the byte parser, applied in arrival order
   typedef enum logic [1:0] {
      JOB_STEP,
      JOB_PRED,
      JOB_ERROR,
      JOB_DATA
   } job_op_type;

   typedef struct packed {
      job_op_type  op;
      logic        channel;
      logic [15:0] word;
      logic [8:0]  subframe;
      logic [7:0]  position;
      logic        eop;
   } job_type;

   localparam logic [14:0] STEP_TABLE [0:88] = '{
      15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
      15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
      15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
      15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
      15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
      15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
      15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
      15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
      15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
      15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086,
      15'd29794, 15'd32767
   };

   // Step size; indexes above the table saturate to the last entry.
   function automatic logic [14:0] step_size(input logic [6:0] idx);
      if (idx > 7'(MAX_STEP_INDEX)) begin
         return STEP_TABLE[MAX_STEP_INDEX];
      end
      return STEP_TABLE[idx];
   endfunction

   // Step index adjustment for one nibble; the sign bit plays no part.
   function automatic logic signed [4:0] index_adjust(input logic [3:0] nib);
      logic signed [4:0] adj;
      case (nib[2:0])
         3'd4:    adj = 5'sd2;
         3'd5:    adj = 5'sd4;
         3'd6:    adj = 5'sd6;
         3'd7:    adj = 5'sd8;
         default: adj = -5'sd1;
      endcase
      return adj;
   endfunction

endpackage

[hdl/ima_adpcm_packet_decoder.sv]
// Top level of the IMA ADPCM packet decoder: byte parser, job register, output register.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_ready    imadec_pkg::req_type (one packet byte)
//   rsp      out  rsp_valid/rsp_ready    imadec_pkg::rsp_type (one sample or error)
//   csr      in   csr_valid/csr_ready    channel_count, 2 bits
//
// A sample byte's two nibbles pass in turn through the one nibble decoder,
// one result per cycle into the output register while that register is
// free and not held by a stalled rsp. Reset is synchronous; afterwards
// bytes are dropped until a packet start. A stalled rsp holds the output
// register while the job register still takes one more request.
`include "ima_adpcm_packet_decoder_assert.svh"

module ima_adpcm_packet_decoder #(
   parameter int SUBFRAME_SAMPLES = 256
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  imadec_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output imadec_pkg::rsp_type rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_data
);

   localparam int SUB_BYTES = SUBFRAME_SAMPLES / 2;
   localparam int K_W       = (SUB_BYTES > 1) ? $clog2(SUB_BYTES) : 1;
   localparam int END_W     = $clog2(65536 + 2 * SUB_BYTES);

   // configuration
   logic [1:0] channel_count_ff, channel_count_in;

   // packet parser state
   logic              stereo_ff,    stereo_in;
   logic [15:0]       packet_len_ff, packet_len_in;
   logic [15:0]       data_len_ff,  data_len_in;
   logic [15:0]       byte_pos_ff,  byte_pos_in;
   logic              discard_ff,   discard_in;
   logic [7:0]        low_hold_ff,  low_hold_in;
   logic [K_W-1:0]    k_ff,         k_in;
   logic              chan_ff,      chan_in;
   logic [8:0]        sf_ff,        sf_in;
   logic [END_W-1:0]  sf_end_ff,    sf_end_in;

   // parser view of the state once a packet start is taken into account
   logic              e_stereo;
   logic [15:0]       e_len;
   logic [15:0]       e_dlen;
   logic [15:0]       e_pos;
   logic              e_discard;
   logic [K_W-1:0]    e_k;
   logic              e_chan;
   logic [8:0]        e_sf;
   logic [END_W-1:0]  e_end;
   logic [15:0]       hdr_bytes;
   logic [END_W-1:0]  group_bytes;
   logic [15:0]       word;
   logic              sf_complete;
   logic              last_sf;

   // job register and nibble phase
   logic                job_valid_ff, job_valid_in;
   imadec_pkg::job_type job_ff;
   imadec_pkg::job_type job_gen;
   logic                job_gen_valid;
   logic                job_done;
   logic                phase_ff, phase_in;

   // channel state
   logic signed [15:0] pred_ff [2];
   logic signed [15:0] pred_in [2];
   logic [6:0]         step_ff [2];
   logic [6:0]         step_in [2];

   // nibble decoder
   logic signed [15:0] nib_sample;
   logic [6:0]         nib_index;
   logic [3:0]         nibble;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   imadec_pkg::rsp_type rsp_ff, rsp_in;
   logic                rsp_load;
   logic                slot_free;

   logic req_fire;

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign channel_count_in = (csr_valid && csr_ready) ? csr_data : channel_count_ff;

   // Restart the packet view on a packet start
   always_comb begin
      if (req_payload.packet_start) begin
         e_stereo = (channel_count_ff == imadec_pkg::CHANNELS_STEREO);
         e_len    = req_payload.packet_bytes;
      end else begin
         e_stereo = stereo_ff;
         e_len    = packet_len_ff;
      end
      hdr_bytes   = e_stereo ? 16'(2 * imadec_pkg::HDR_BYTES_PER_CHANNEL)
                             : 16'(imadec_pkg::HDR_BYTES_PER_CHANNEL);
      group_bytes = e_stereo ? END_W'(2 * SUB_BYTES) : END_W'(SUB_BYTES);
      if (req_payload.packet_start) begin
         e_dlen    = e_len - hdr_bytes;
         e_pos     = '0;
         e_discard = (e_len < hdr_bytes);
         e_k       = '0;
         e_chan    = 1'b0;
         e_sf      = '0;
         e_end     = group_bytes;
      end else begin
         e_dlen    = data_len_ff;
         e_pos     = byte_pos_ff;
         e_discard = discard_ff;
         e_k       = k_ff;
         e_chan    = chan_ff;
         e_sf      = sf_ff;
         e_end     = sf_end_ff;
      end
   end

   assign word        = {req_payload.data_byte, low_hold_ff};
   assign sf_complete = (e_end <= END_W'(e_dlen));
   assign last_sf     = (e_end + group_bytes > END_W'(e_dlen));

   // Parse the accepted byte and queue the work it causes
   always_comb begin
      stereo_in     = stereo_ff;
      packet_len_in = packet_len_ff;
      data_len_in   = data_len_ff;
      byte_pos_in   = byte_pos_ff;
      discard_in    = discard_ff;
      low_hold_in   = low_hold_ff;
      k_in          = k_ff;
      chan_in       = chan_ff;
      sf_in         = sf_ff;
      sf_end_in     = sf_end_ff;
      job_gen_valid = 1'b0;
      job_gen.op       = imadec_pkg::JOB_DATA;
      job_gen.channel  = e_chan;
      job_gen.word     = {8'h00, req_payload.data_byte};
      job_gen.subframe = e_sf;
      job_gen.position = 8'({e_k, 1'b0});
      job_gen.eop      = 1'b0;
      if (req_fire) begin
         stereo_in     = e_stereo;
         packet_len_in = e_len;
         data_len_in   = e_dlen;
         byte_pos_in   = e_pos;
         discard_in    = e_discard;
         k_in          = e_k;
         chan_in       = e_chan;
         sf_in         = e_sf;
         sf_end_in     = e_end;
         if (!e_discard) begin
            if (e_pos >= e_len) begin
               // past the packet length: drop until the next start
               discard_in = 1'b1;
            end else begin
               byte_pos_in = e_pos + 16'd1;
               if (e_pos < hdr_bytes) begin
                  job_gen.channel = e_pos[2];
                  job_gen.word    = word;
                  case (e_pos[1:0])
                     2'd1: begin
                        job_gen_valid = 1'b1;
                        if (word > 16'(imadec_pkg::MAX_STEP_INDEX)) begin
                           discard_in = 1'b1;
                           job_gen.op = imadec_pkg::JOB_ERROR;
                        end else begin
                           job_gen.op = imadec_pkg::JOB_STEP;
                        end
                     end
                     2'd3: begin
                        job_gen_valid = 1'b1;
                        job_gen.op    = imadec_pkg::JOB_PRED;
                     end
                     default: begin
                        low_hold_in = req_payload.data_byte;
                     end
                  endcase
               end else if (sf_complete) begin
                  // sample byte of a complete subframe
                  job_gen_valid = 1'b1;
                  job_gen.eop   = last_sf && (e_chan == e_stereo) &&
                                  (e_k == K_W'(SUB_BYTES - 1));
                  if (e_k == K_W'(SUB_BYTES - 1)) begin
                     k_in = '0;
                     if (e_chan == e_stereo) begin
                        chan_in   = 1'b0;
                        sf_in     = e_sf + 9'd1;
                        sf_end_in = e_end + group_bytes;
                     end else begin
                        chan_in = 1'b1;
                     end
                  end else begin
                     k_in = e_k + K_W'(1);
                  end
               end
            end
         end
      end
   end

   // Decode the nibble that the current phase selects
   assign nibble = phase_ff ? job_ff.word[7:4] : job_ff.word[3:0];

   imadec_nibble u_nibble (
      .predictor  (pred_ff[job_ff.channel]),
      .step_index (step_ff[job_ff.channel]),
      .nibble     (nibble),
      .sample     (nib_sample),
      .next_index (nib_index)
   );

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Apply the queued job to the channel state and fill the output register
   always_comb begin
      job_done = 1'b0;
      rsp_load = 1'b0;
      phase_in = phase_ff;
      pred_in  = pred_ff;
      step_in  = step_ff;
      rsp_in.result_kind     = imadec_pkg::KIND_SAMPLE;
      rsp_in.sample_value    = nib_sample;
      rsp_in.channel_number  = job_ff.channel;
      rsp_in.subframe_number = job_ff.subframe;
      rsp_in.sample_position = {job_ff.position[7:1], phase_ff};
      rsp_in.last_of_item    = phase_ff;
      rsp_in.end_of_packet   = phase_ff && job_ff.eop;
      if (job_valid_ff) begin
         unique case (job_ff.op)
            imadec_pkg::JOB_STEP: begin
               step_in[job_ff.channel] = job_ff.word[6:0];
               job_done = 1'b1;
            end
            imadec_pkg::JOB_PRED: begin
               pred_in[job_ff.channel] = $signed(job_ff.word);
               job_done = 1'b1;
            end
            imadec_pkg::JOB_ERROR: begin
               rsp_in.result_kind     = imadec_pkg::KIND_ERROR;
               rsp_in.sample_value    = '0;
               rsp_in.subframe_number = '0;
               rsp_in.sample_position = '0;
               rsp_in.last_of_item    = 1'b1;
               rsp_in.end_of_packet   = 1'b0;
               if (slot_free) begin
                  rsp_load = 1'b1;
                  job_done = 1'b1;
               end
            end
            imadec_pkg::JOB_DATA: begin
               if (slot_free) begin
                  rsp_load = 1'b1;
                  pred_in[job_ff.channel] = nib_sample;
                  step_in[job_ff.channel] = nib_index;
                  phase_in = !phase_ff;
                  job_done = phase_ff;
               end
            end
            default: begin
               job_done = 1'b1;
            end
         endcase
      end
   end

   assign req_ready    = !job_valid_ff || job_done;
   assign job_valid_in = job_gen_valid || (job_valid_ff && !job_done);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Control and channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= imadec_pkg::CHANNELS_MONO;
         stereo_ff        <= 1'b0;
         packet_len_ff    <= '0;
         data_len_ff      <= '0;
         byte_pos_ff      <= '0;
         discard_ff       <= 1'b1;
         low_hold_ff      <= '0;
         k_ff             <= '0;
         chan_ff          <= 1'b0;
         sf_ff            <= '0;
         sf_end_ff        <= '0;
         job_valid_ff     <= 1'b0;
         phase_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         pred_ff          <= '{default: '0};
         step_ff          <= '{default: '0};
      end else begin
         channel_count_ff <= channel_count_in;
         stereo_ff        <= stereo_in;
         packet_len_ff    <= packet_len_in;
         data_len_ff      <= data_len_in;
         byte_pos_ff      <= byte_pos_in;
         discard_ff       <= discard_in;
         low_hold_ff      <= low_hold_in;
         k_ff             <= k_in;
         chan_ff          <= chan_in;
         sf_ff            <= sf_in;
         sf_end_ff        <= sf_end_in;
         job_valid_ff     <= job_valid_in;
         phase_ff         <= phase_in;
         rsp_valid_ff     <= rsp_valid_in;
         pred_ff          <= pred_in;
         step_ff          <= step_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (job_gen_valid) begin
         job_ff <= job_gen;
      end
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Step indexes stay inside the table
   `IMADEC_ASSERT_IMPLY(a_step_range, clock, reset, 1'b1,
      (step_ff[0] <= 7'(imadec_pkg::MAX_STEP_INDEX)) &&
      (step_ff[1] <= 7'(imadec_pkg::MAX_STEP_INDEX)))

   // High nibble phase only while a sample byte is held
   `IMADEC_ASSERT_IMPLY(a_phase_data, clock, reset, phase_ff,
      job_valid_ff && (job_ff.op == imadec_pkg::JOB_DATA))

   // A low nibble result is followed by the high nibble of the same byte
   `IMADEC_ASSERT_NEXT(a_low_then_high, clock, reset,
      job_valid_ff && (job_ff.op == imadec_pkg::JOB_DATA) && !phase_ff && slot_free,
      phase_ff && job_valid_ff && rsp_valid_ff)

   // Error results close their byte and carry no sample
   `IMADEC_ASSERT_IMPLY(a_error_shape, clock, reset,
      rsp_valid_ff && (rsp_ff.result_kind == imadec_pkg::KIND_ERROR),
      rsp_ff.last_of_item && !rsp_ff.end_of_packet && (rsp_ff.sample_value == 16'sd0))

endmodule

[hdl/imadec_nibble.sv]
// One IMA ADPCM nibble decode: predictor update, clamping and step index update.
module imadec_nibble (
   input  logic signed [15:0] predictor,
   input  logic [6:0]         step_index,
   input  logic [3:0]         nibble,
   output logic signed [15:0] sample,
   output logic [6:0]         next_index
);

   logic [14:0]        step;
   logic [3:0]         odd_mult;
   logic [18:0]        product;
   logic [15:0]        diff;
   logic signed [17:0] pred_ext;
   logic signed [17:0] diff_ext;
   logic signed [17:0] sum;
   logic signed [4:0]  adjust;
   logic signed [7:0]  idx_sum;

   // Scale the step by (2 * magnitude + 1) / 8
   assign step     = imadec_pkg::step_size(step_index);
   assign odd_mult = {nibble[2:0], 1'b1};
   assign product  = 19'(odd_mult) * 19'(step);
   assign diff     = product[18:3];

   // Add or subtract the difference, then clamp to 16 bits
   assign pred_ext = {{2{predictor[15]}}, predictor};
   assign diff_ext = $signed({2'b00, diff});
   assign sum      = nibble[3] ? (pred_ext - diff_ext) : (pred_ext + diff_ext);

   always_comb begin
      if (sum < 18'(imadec_pkg::SAMPLE_MIN)) begin
         sample = imadec_pkg::SAMPLE_MIN;
      end else if (sum > 18'(imadec_pkg::SAMPLE_MAX)) begin
         sample = imadec_pkg::SAMPLE_MAX;
      end else begin
         sample = sum[15:0];
      end
   end

   // Move the step index and hold it within the table
   assign adjust  = imadec_pkg::index_adjust(nibble);
   assign idx_sum = $signed({1'b0, step_index}) + {{3{adjust[4]}}, adjust};

   always_comb begin
      if (idx_sum < 8'sd0) begin
         next_index = '0;
      end else if (idx_sum > 8'(imadec_pkg::MAX_STEP_INDEX)) begin
         next_index = 7'(imadec_pkg::MAX_STEP_INDEX);
      end else begin
         next_index = idx_sum[6:0];
      end
   end

endmodule
